@@ rtl/crlf_pkg.sv @@
package crlf_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TAKE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] KIND_ERR  = 2'd0;
  localparam logic [1:0] KIND_TAKE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] REPLY_ADDR = 8'h01;
  localparam logic [7:0] REPLY_PORT = 8'h3f;
  localparam logic [7:0] REPLY_TYPE = 8'h01;

  localparam logic [1:0] REPLY_FIRST = 2'd0;
  localparam logic [1:0] REPLY_MID   = 2'd1;
  localparam logic [1:0] REPLY_END   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } rx_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [6:0] line_count;
    logic       line_overflow;
    logic [7:0] read_data;
    logic       last;
  } res_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] line_count;
    logic       line_overflow;
    logic       in_range;
  } pend_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] line_count;
    logic       line_overflow;
    logic [7:0] read_data;
    logic [1:0] phase;
  } hold_t;

endpackage

@@ rtl/crlf_in_if.sv @@
interface crlf_in_if import crlf_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/crlf_out_if.sv @@
interface crlf_out_if import crlf_pkg::*; ();
  logic      valid;
  logic      ready;
  res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/crlf_line_receiver_unit.sv @@
// channel   dir  word        payload
// rx_in     in   rx_word_t   mode, rx_byte, read_index
// res_out   out  res_word_t  kind, tx_byte, line_count, line_overflow, read_data, last
//
// One word per cycle while ready; each result moves pending stage -> output register.
// An error reply holds the output for three words; a held line stalls only then.
// Line buffer is one synchronous RAM: one write or one read per accepted word.
// rst clears counters and flags; buffer contents stay undefined until written.
// A pending stage and an output register let one word enter while a result waits.
module crlf_line_receiver_unit import crlf_pkg::*; (
  input logic         clk,
  input logic         rst,
  crlf_in_if.sink     rx_in,
  crlf_out_if.source  res_out
);

  logic [7:0]       line_buffer [LINE_DEPTH];
  logic [7:0]       rd_q;
  logic [CNT_W-1:0] byte_count;
  logic             line_ready;
  logic             overflowed;
  logic [7:0]       previous_byte;

  logic  a_valid;
  pend_t a_q;
  logic  out_valid;
  hold_t out_q;

  logic              in_acc;
  logic              out_last;
  logic              out_done;
  logic              a_move;
  logic              gives_result;
  logic              buf_full;
  logic              store_byte;
  logic              line_end;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;

  assign in_acc      = rx_in.valid && rx_in.ready;
  assign out_last    = (out_q.kind != KIND_ERR) || (out_q.phase == REPLY_END);
  assign out_done    = out_valid && res_out.ready && out_last;
  assign a_move      = a_valid && (!out_valid || out_done);
  assign rx_in.ready = !a_valid || a_move;

  assign buf_full    = (byte_count == CNT_W'(LINE_DEPTH));
  assign store_byte  = in_acc && (rx_in.data.mode == MODE_BYTE) && !line_ready && !buf_full;
  assign line_end    = (rx_in.data.rx_byte == CHAR_LF) && (byte_count != '0)
                       && (previous_byte == CHAR_CR);
  assign rd_addr     = ADDR_W'(rx_in.data.read_index);
  assign rd_in_range = 32'(rx_in.data.read_index) < LINE_DEPTH;

  assign gives_result = (rx_in.data.mode == MODE_TAKE) || (rx_in.data.mode == MODE_READ)
                        || ((rx_in.data.mode == MODE_BYTE) && line_ready);

  always_ff @(posedge clk) begin
    if (store_byte) begin
      line_buffer[byte_count[ADDR_W-1:0]] <= rx_in.data.rx_byte;
    end
    if (in_acc && (rx_in.data.mode == MODE_READ)) begin
      rd_q <= line_buffer[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      line_ready    <= 1'b0;
      overflowed    <= 1'b0;
      previous_byte <= '0;
    end else if (in_acc) begin
      unique case (rx_in.data.mode)
        MODE_BYTE: begin
          if (!line_ready) begin
            if (line_end) begin
              line_ready <= 1'b1;
            end
            if (buf_full) begin
              overflowed <= 1'b1;
            end else begin
              byte_count <= byte_count + 1'b1;
            end
            previous_byte <= rx_in.data.rx_byte;
          end
        end
        MODE_TAKE: begin
          if (line_ready) begin
            byte_count <= '0;
            line_ready <= 1'b0;
            overflowed <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc && gives_result) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_q.kind          <= (rx_in.data.mode == MODE_BYTE) ? KIND_ERR : rx_in.data.mode;
      a_q.line_count    <= (line_ready && (rx_in.data.mode == MODE_TAKE))
                           ? 7'(byte_count) : 7'd0;
      a_q.line_overflow <= (rx_in.data.mode == MODE_TAKE) && overflowed;
      a_q.in_range      <= rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      out_q.phase <= REPLY_FIRST;
    end else if (a_move) begin
      out_valid   <= 1'b1;
      out_q.phase <= REPLY_FIRST;
    end else if (out_valid && res_out.ready) begin
      if (out_last) begin
        out_valid <= 1'b0;
      end else begin
        out_q.phase <= out_q.phase + 1'b1;
      end
    end
    if (a_move) begin
      out_q.kind          <= a_q.kind;
      out_q.line_count    <= a_q.line_count;
      out_q.line_overflow <= a_q.line_overflow;
      out_q.read_data     <= (a_q.kind == KIND_READ && a_q.in_range) ? rd_q : 8'd0;
    end
  end

  always_comb begin
    res_out.data = '0;
    res_out.data.kind = out_q.kind;
    res_out.data.last = out_last;
    unique case (out_q.kind)
      KIND_ERR: begin
        unique case (out_q.phase)
          REPLY_FIRST: res_out.data.tx_byte = REPLY_ADDR;
          REPLY_MID:   res_out.data.tx_byte = REPLY_PORT;
          default:     res_out.data.tx_byte = REPLY_TYPE;
        endcase
      end
      KIND_TAKE: begin
        res_out.data.line_count    = out_q.line_count;
        res_out.data.line_overflow = out_q.line_overflow;
      end
      KIND_READ: res_out.data.read_data = out_q.read_data;
      default: ;
    endcase
  end

  assign res_out.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(LINE_DEPTH))
    else $error("byte count beyond buffer depth");

  a_ready_len: assert property (@(posedge clk) disable iff (rst)
    line_ready |-> byte_count >= CNT_W'(2))
    else $error("held line shorter than CR LF");

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    in_acc && (rx_in.data.mode == MODE_TAKE) && line_ready |=> (byte_count == '0) && !line_ready)
    else $error("take did not free the buffer");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && out_valid && !res_out.ready |=> a_valid)
    else $error("pending result lost under stall");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.phase != 2'd3))
    else $error("reply phase out of range");

endmodule

@@ dv/crlf_line_receiver_unit_test.sv @@
`timescale 1ns / 100ps

module crlf_line_receiver_unit_test;
  import crlf_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [7:0]       line_mem [LINE_DEPTH];
    logic [CNT_W-1:0] fill;
    logic             held;
    logic             dropped;
    logic [7:0]       prev_char;
    int               high_mark;
  } line_state_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_off;

  crlf_in_if  rx_in ();
  crlf_out_if res_out ();

  crlf_line_receiver_unit dut (
    .clk    (clk),
    .rst    (rst),
    .rx_in  (rx_in),
    .res_out(res_out)
  );

  rx_word_t    rx_backlog [$];
  res_word_t   owed_results [$];
  line_state_t model_state;
  line_state_t plan_state;
  res_word_t   want;
  int          words_sent;
  int          total_words;
  int          counted_words;
  int          fault_count;
  int          send_gap;
  int          take_gap;
  int          send_calm;
  int          recv_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_line(ref line_state_t s);
    foreach (s.line_mem[i]) s.line_mem[i] = '0;
    s.fill = '0;
    s.held = 1'b0;
    s.dropped = 1'b0;
    s.prev_char = '0;
    s.high_mark = 0;
  endfunction

  // Apply one word to the line state and append the results it causes.
  function automatic void advance_line(ref line_state_t s, input rx_word_t w,
                                       ref res_word_t q[$]);
    res_word_t r;
    r = '0;
    case (w.mode)
      MODE_BYTE: begin
        if (s.held) begin
          r.kind = KIND_ERR;
          r.tx_byte = REPLY_ADDR;
          q.push_back(r);
          r.tx_byte = REPLY_PORT;
          q.push_back(r);
          r.tx_byte = REPLY_TYPE;
          r.last = 1'b1;
          q.push_back(r);
        end else begin
          if (w.rx_byte == CHAR_LF && s.fill != 0 && s.prev_char == CHAR_CR) s.held = 1'b1;
          if (s.fill < LINE_DEPTH) begin
            s.line_mem[s.fill[ADDR_W-1:0]] = w.rx_byte;
            s.fill++;
            if (int'(s.fill) > s.high_mark) s.high_mark = int'(s.fill);
          end else begin
            s.dropped = 1'b1;
          end
          s.prev_char = w.rx_byte;
        end
      end
      MODE_TAKE: begin
        r.kind = KIND_TAKE;
        r.line_count = s.held ? s.fill : '0;
        r.line_overflow = s.dropped;
        r.last = 1'b1;
        q.push_back(r);
        if (s.held) begin
          s.fill = '0;
          s.held = 1'b0;
          s.dropped = 1'b0;
        end
      end
      MODE_READ: begin
        r.kind = KIND_READ;
        r.read_data = s.line_mem[w.read_index];
        r.last = 1'b1;
        q.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_word(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [5:0] idx);
    rx_word_t  w;
    res_word_t scratch [$];
    w.mode = mode;
    w.rx_byte = ch;
    w.read_index = idx;
    rx_backlog.push_back(w);
    advance_line(plan_state, w, scratch);
    if (mode != MODE_NONE) counted_words++;
  endtask

  task automatic push_byte(input logic [7:0] ch);
    push_word(MODE_BYTE, ch, 6'($urandom_range(0, 63)));
  endtask

  task automatic push_take();
    push_word(MODE_TAKE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
  endtask

  // Read only entries already written since reset.
  task automatic push_read();
    if (plan_state.high_mark > 0) begin
      push_word(MODE_READ, 8'($urandom_range(0, 255)),
                6'($urandom_range(0, plan_state.high_mark - 1)));
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_in.valid <= 1'b0;
      rx_in.data <= '0;
      send_gap = 0;
    end else begin
      if (rx_in.valid && rx_in.ready) begin
        advance_line(model_state, rx_in.data, owed_results);
        words_sent++;
        send_gap = pick_gap(send_calm);
      end
      if (!rx_in.valid || rx_in.ready) begin
        if (send_gap == 0 && rx_backlog.size() > 0) begin
          rx_in.valid <= 1'b1;
          rx_in.data <= rx_backlog.pop_front();
        end else begin
          if (send_gap > 0) send_gap--;
          rx_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: kind %0d", res_out.data.kind);
          fault_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", int'(want.kind), int'(res_out.data.kind));
          check_field("tx_byte", int'(want.tx_byte), int'(res_out.data.tx_byte));
          check_field("line_count", int'(want.line_count), int'(res_out.data.line_count));
          check_field("line_overflow", int'(want.line_overflow),
                      int'(res_out.data.line_overflow));
          check_field("read_data", int'(want.read_data), int'(res_out.data.read_data));
          check_field("last", int'(want.last), int'(res_out.data.last));
        end
        take_gap = pick_gap(recv_calm);
      end
      if (hold_off) begin
        res_out.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  // Hold the result side off long enough for the block to back up.
  initial begin
    hold_off = 1'b0;
    wait (words_sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5000000;
    $display("crlf_line_receiver_unit_test: done, errors");
    $finish;
  end

  initial begin
    int  r;
    int  len;
    int  extras;
    bit  first_long;
    rst = 1'b1;
    rx_in.valid = 1'b0;
    rx_in.data = '0;
    res_out.ready = 1'b0;
    words_sent = 0;
    counted_words = 0;
    fault_count = 0;
    send_calm = 0;
    recv_calm = 0;
    clear_line(model_state);
    clear_line(plan_state);

    push_word(MODE_TAKE, 8'hff, 6'h3f);
    push_word(MODE_NONE, 8'h5a, 6'h2a);
    push_word(MODE_NONE, 8'ha5, 6'h15);
    push_byte(CHAR_LF);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte(8'h41);
    for (int i = 0; i < 5; i++) push_word(MODE_READ, 8'h00, 6'(i));
    push_take();
    push_take();
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_word(MODE_READ, 8'hff, 6'd2);
    push_take();
    push_byte(CHAR_CR);
    push_byte(8'h41);
    push_byte(CHAR_LF);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_take();

    first_long = 1'b1;
    while (counted_words < 350) begin
      r = $urandom_range(0, 99);
      if (first_long || r < 5) begin
        len = $urandom_range(LINE_DEPTH - 3, LINE_DEPTH + 6);
        first_long = 1'b0;
      end else begin
        len = $urandom_range(0, 8);
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 39))
          0: push_read();
          1: push_take();
          2: push_word(MODE_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 82) begin
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end else if (r < 91) begin
        push_byte(CHAR_LF);
      end else begin
        push_byte(CHAR_CR);
        push_byte(8'($urandom_range(11, 255)));
      end
      extras = $urandom_range(0, 3);
      for (int i = 0; i < extras; i++) begin
        case ($urandom_range(0, 3))
          0: push_byte(8'($urandom_range(0, 255)));
          1: push_word(MODE_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
          default: push_read();
        endcase
      end
      if ($urandom_range(0, 9) != 0) push_take();
    end
    total_words = rx_backlog.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (words_sent == total_words);
    wait (owed_results.size() == 0);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("crlf_line_receiver_unit_test: done, clean");
    end else begin
      $display("crlf_line_receiver_unit_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/crlf_pkg.sv
rtl/crlf_in_if.sv
rtl/crlf_out_if.sv
rtl/crlf_line_receiver_unit.sv
dv/crlf_line_receiver_unit_test.sv
